// ===== rtl/mmts_pkg.sv =====
package mmts_pkg;

    // March phase codes
    localparam logic [1:0] PH_FILL = 2'd0;
    localparam logic [1:0] PH_ASC  = 2'd1;
    localparam logic [1:0] PH_DESC = 2'd2;

    // Pattern index range: 0..PATTERN_LAST, the last index gives zero
    localparam logic [7:0] PATTERN_LAST = 8'd128;

    // Configuration register indexes
    localparam logic [1:0] CFG_WORD_COUNT = 2'd0;
    localparam logic [1:0] CFG_PASSES     = 2'd1;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] word_address;
        logic [7:0]  pass_counter;
        logic [7:0]  pattern_index;
        logic [31:0] mismatch_count;
    } t_state;

    typedef struct packed {
        logic [15:0] access_address;
        logic [31:0] write_data;
        logic        compared;
        logic        mismatch;
        logic [31:0] error_total;
        logic [31:0] pattern_value;
        logic [15:0] next_address;
        logic        pass_done;
    } t_result;

    // Walking 1, 11, 101 or 111 across 32 bits; top index gives zero
    function automatic logic [31:0] pattern_of(input logic [7:0] idx);
        logic [31:0] base;
        base = 32'd0;
        case (idx[7:5])
            3'd0:    base = 32'd1;
            3'd1:    base = 32'd3;
            3'd2:    base = 32'd5;
            3'd3:    base = 32'd7;
            default: base = 32'd0;
        endcase
        return base << idx[4:0];
    endfunction

endpackage

// ===== rtl/mmts_step.sv =====
module mmts_step (
    input  mmts_pkg::t_state  i_state,
    input  logic [15:0]       i_last,
    input  logic [7:0]        i_passes,
    input  logic [31:0]       i_read_data,
    output mmts_pkg::t_state  o_state,
    output mmts_pkg::t_result o_result
);
    import mmts_pkg::*;

    logic [31:0] pat;
    logic [31:0] comp;
    logic [8:0]  pass_next;
    logic        mis;

    assign pat       = pattern_of(i_state.pattern_index);
    assign comp      = ~pat;
    assign pass_next = {1'b0, i_state.pass_counter} + 9'd1;

    // Advance the march by one access
    always_comb begin
        o_state = i_state;
        mis     = 1'b0;
        o_result.compared  = 1'b0;
        o_result.pass_done = 1'b0;
        o_result.write_data = pat;
        case (i_state.phase)
            PH_ASC: begin
                o_result.compared   = 1'b1;
                mis                 = (i_read_data != pat);
                o_result.write_data = comp;
                if (i_state.word_address >= i_last) begin
                    o_state.phase        = PH_DESC;
                    o_state.word_address = i_last;
                end else begin
                    o_state.word_address = i_state.word_address + 16'd1;
                end
            end
            PH_DESC: begin
                o_result.compared = 1'b1;
                mis               = (i_read_data != comp);
                if (i_state.word_address == 16'd0) begin
                    o_result.pass_done = 1'b1;
                    o_state.phase      = PH_FILL;
                    if (pass_next >= {1'b0, i_passes}) begin
                        o_state.pass_counter  = 8'd0;
                        o_state.pattern_index = (i_state.pattern_index >= PATTERN_LAST) ?
                                                8'd0 : i_state.pattern_index + 8'd1;
                    end else begin
                        o_state.pass_counter = pass_next[7:0];
                    end
                end else begin
                    o_state.word_address = i_state.word_address - 16'd1;
                end
            end
            default: begin
                o_state.phase = PH_FILL;
                if (i_state.word_address >= i_last) begin
                    o_state.phase        = PH_ASC;
                    o_state.word_address = 16'd0;
                end else begin
                    o_state.word_address = i_state.word_address + 16'd1;
                end
            end
        endcase

        // Count mismatches, hold at the maximum
        if (mis && (i_state.mismatch_count != 32'hFFFF_FFFF)) begin
            o_state.mismatch_count = i_state.mismatch_count + 32'd1;
        end

        o_result.access_address = i_state.word_address;
        o_result.mismatch       = mis;
        o_result.error_total    = o_state.mismatch_count;
        o_result.pattern_value  = pat;
        o_result.next_address   = o_state.word_address;
    end

endmodule

// ===== rtl/march_memory_test_sequencer_unit.sv =====
// An accepted item's result is registered in the output register, or in the skid register
// while the output waits. Throughput: one item per cycle, set by the step logic between the
// state and result registers; the skid keeps input accepted until it holds a result itself.
// Reset (i_rst_n low, synchronous): fill phase at address 0, pass, pattern and error
// counts cleared, word_count 65536, passes_per_pattern 4, output and skid empty.
module march_memory_test_sequencer_unit #(
    parameter int MAX_WORDS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_read_data,
    // Result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_access_address,
    output logic [31:0] o_write_data,
    output logic        o_compared,
    output logic        o_mismatch,
    output logic [31:0] o_error_total,
    output logic [31:0] o_pattern_value,
    output logic [15:0] o_next_address,
    output logic        o_pass_done,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import mmts_pkg::*;

    localparam int WORD_LIMIT = (MAX_WORDS < 65536) ? MAX_WORDS : 65536;
    localparam logic [16:0] LIMIT = 17'(WORD_LIMIT);

    logic [16:0] r_word_count;
    logic [7:0]  r_passes;
    t_state      r_state;
    t_state      n_state;
    t_result     step_res;
    t_result     r_out;
    t_result     r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;
    logic [16:0] words;
    logic [15:0] last;
    logic [7:0]  passes;
    logic        in_fire;
    logic        out_fire;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;

    // Clamp the configuration to usable values
    always_comb begin
        words = r_word_count;
        if (words == 17'd0) begin
            words = 17'd1;
        end
        if (words > LIMIT) begin
            words = LIMIT;
        end
    end
    assign last   = 16'(words - 17'd1);
    assign passes = (r_passes == 8'd0) ? 8'd1 : r_passes;

    mmts_step u_step (
        .i_state     (r_state),
        .i_last      (last),
        .i_passes    (passes),
        .i_read_data (i_read_data),
        .o_state     (n_state),
        .o_result    (step_res)
    );

    // Write configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count <= 17'h1_0000;
            r_passes     <= 8'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WORD_COUNT: r_word_count <= i_cfg_data;
                CFG_PASSES:     r_passes     <= i_cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // Advance march state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_FILL;
            r_state.word_address   <= 16'd0;
            r_state.pass_counter   <= 8'd0;
            r_state.pattern_index  <= 8'd0;
            r_state.mismatch_count <= 32'd0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Output register with skid stage
    assign o_in_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_fire) begin
                r_out_valid  <= r_skid_valid || in_fire;
                r_skid_valid <= 1'b0;
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Route result payload into output or skid
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : step_res;
        end
        if (in_fire && r_out_valid && !out_fire) begin
            r_skid <= step_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_access_address = r_out.access_address;
    assign o_write_data     = r_out.write_data;
    assign o_compared       = r_out.compared;
    assign o_mismatch       = r_out.mismatch;
    assign o_error_total    = r_out.error_total;
    assign o_pattern_value  = r_out.pattern_value;
    assign o_next_address   = r_out.next_address;
    assign o_pass_done      = r_out.pass_done;

endmodule

// ===== test/march_memory_test_sequencer_unit_test.sv =====
`timescale 1ns / 1ps

module march_memory_test_sequencer_unit_test;
    import mmts_pkg::*;

    localparam int WORDS_LIMIT  = 65536;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    // Register indexes that decode to nothing
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_read_data = 32'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_access_address;
    logic [31:0] o_write_data;
    logic        o_compared;
    logic        o_mismatch;
    logic [31:0] o_error_total;
    logic [31:0] o_pattern_value;
    logic [15:0] o_next_address;
    logic        o_pass_done;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_WORD_COUNT;
    logic [16:0] i_cfg_data = 17'd0;

    // March state as the block should hold it
    logic [1:0]  march_phase = PH_FILL;
    logic [15:0] march_addr = 16'd0;
    logic [7:0]  pass_cnt = 8'd0;
    logic [7:0]  pat_idx = 8'd0;
    logic [31:0] err_cnt = 32'd0;
    logic [16:0] cfg_words = 17'd65536;
    logic [7:0]  cfg_passes = 8'd4;

    // Image of the memory under test, updated with every predicted write
    bit [31:0] mem_image [0:65535];

    t_result expected_steps [$];
    int check_failures = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    march_memory_test_sequencer_unit #(
        .MAX_WORDS(WORDS_LIMIT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_read_data     (i_read_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_access_address(o_access_address),
        .o_write_data    (o_write_data),
        .o_compared      (o_compared),
        .o_mismatch      (o_mismatch),
        .o_error_total   (o_error_total),
        .o_pattern_value (o_pattern_value),
        .o_next_address  (o_next_address),
        .o_pass_done     (o_pass_done),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Walking 1, 11, 101, 111; index 128 and above gives zero
    function automatic logic [31:0] walking_pattern(input logic [7:0] idx);
        logic [4:0] sh;
        sh = idx[4:0];
        if (idx < 8'd32) return 32'd1 << sh;
        else if (idx < 8'd64) return 32'd3 << sh;
        else if (idx < 8'd96) return 32'd5 << sh;
        else if (idx < 8'd128) return 32'd7 << sh;
        return 32'd0;
    endfunction

    // Advance the march by one access slot and queue the result item
    task automatic march_step(input logic [31:0] rd);
        logic [16:0] words;
        logic [16:0] last_word;
        logic [7:0]  passes;
        logic [31:0] pat;
        t_result     r;
        words = cfg_words;
        if (words == 17'd0) words = 17'd1;
        if (words > WORDS_LIMIT) words = 17'(WORDS_LIMIT);
        if (words > 17'd65536) words = 17'd65536;
        last_word = words - 17'd1;
        passes = (cfg_passes == 8'd0) ? 8'd1 : cfg_passes;
        pat = walking_pattern(pat_idx);
        r.access_address = march_addr;
        r.pattern_value = pat;
        r.compared = 1'b0;
        r.mismatch = 1'b0;
        r.pass_done = 1'b0;
        case (march_phase)
            PH_ASC: begin
                r.compared = 1'b1;
                r.mismatch = (rd != pat);
                r.write_data = ~pat;
                if ({1'b0, march_addr} >= last_word) begin
                    march_phase = PH_DESC;
                    march_addr = last_word[15:0];
                end else begin
                    march_addr = march_addr + 16'd1;
                end
            end
            PH_DESC: begin
                r.compared = 1'b1;
                r.mismatch = (rd != ~pat);
                r.write_data = pat;
                if (march_addr == 16'd0) begin
                    r.pass_done = 1'b1;
                    march_phase = PH_FILL;
                    if ({1'b0, pass_cnt} + 9'd1 >= {1'b0, passes}) begin
                        pass_cnt = 8'd0;
                        pat_idx = (pat_idx >= PATTERN_LAST) ? 8'd0 : pat_idx + 8'd1;
                    end else begin
                        pass_cnt = pass_cnt + 8'd1;
                    end
                end else begin
                    march_addr = march_addr - 16'd1;
                end
            end
            default: begin
                r.write_data = pat;
                if ({1'b0, march_addr} >= last_word) begin
                    march_phase = PH_ASC;
                    march_addr = 16'd0;
                end else begin
                    march_phase = PH_FILL;
                    march_addr = march_addr + 16'd1;
                end
            end
        endcase
        if (r.mismatch && err_cnt != 32'hFFFF_FFFF) err_cnt = err_cnt + 32'd1;
        r.error_total = err_cnt;
        r.next_address = march_addr;
        mem_image[r.access_address] = r.write_data;
        expected_steps.push_back(r);
    endtask

    // Word stored at the announced address, corrupted now and then
    function automatic logic [31:0] next_read_word(input int corrupt_pct);
        logic [31:0] w;
        w = mem_image[march_addr];
        if ($urandom_range(99) < corrupt_pct) begin
            case ($urandom_range(2))
                0: w = w ^ (32'd1 << $urandom_range(31));
                1: w = $urandom;
                default: w = ~w;
            endcase
        end
        return w;
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(input logic [31:0] rd);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_read_data <= rd;
        do @(posedge i_clk); while (!o_in_ready);
        march_step(rd);
    endtask

    // Drop the input, drain all results, then write one register
    task automatic write_register(input logic [1:0] index, input logic [16:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_WORD_COUNT) cfg_words = value;
        else if (index == CFG_PASSES) cfg_passes = value[7:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s wrong: expected %h, actual %h", $time, field, want, got);
            check_failures++;
        end
    endfunction

    // Compare each accepted result item with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (o_out_valid && i_out_ready) begin
            if (expected_steps.size() == 0) begin
                $display("%0t: unexpected result item: expected none, actual address %h",
                         $time, o_access_address);
                check_failures++;
            end else begin
                want = expected_steps.pop_front();
                check_field("access_address", 32'(want.access_address), 32'(o_access_address));
                check_field("write_data", want.write_data, o_write_data);
                check_field("compared", 32'(want.compared), 32'(o_compared));
                check_field("mismatch", 32'(want.mismatch), 32'(o_mismatch));
                check_field("error_total", want.error_total, o_error_total);
                check_field("pattern_value", want.pattern_value, o_pattern_value);
                check_field("next_address", 32'(want.next_address), 32'(o_next_address));
                check_field("pass_done", 32'(want.pass_done), 32'(o_pass_done));
            end
        end
    end

    // Stall the result side at random, or hold it off for a long stretch
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run if no channel moves an item for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Fill from reset defaults, clamp the word count, then shrink it mid-fill
    task automatic test_fill_and_clamp();
        int i;
        send_item(32'h0000_0000);
        send_item(32'hFFFF_FFFF);
        send_item(32'hA5A5_5A5A);
        send_item(32'h5A5A_A5A5);
        write_register(CFG_WORD_COUNT, 17'h1_FFFF);
        send_item(next_read_word(0));
        // fill address already past the new last word ends the fill here
        write_register(CFG_WORD_COUNT, 17'd3);
        for (i = 0; i < 7; i++) send_item(next_read_word((i == 2 || i == 5) ? 100 : 0));
    endtask

    // Zero word count and zero passes act as one; spare indexes change nothing
    task automatic test_zero_registers();
        int i;
        write_register(CFG_SPARE_LO, 17'h1_FFFF);
        write_register(CFG_SPARE_HI, 17'h1_FFFF);
        write_register(CFG_WORD_COUNT, 17'd0);
        write_register(CFG_PASSES, 17'h1_0000);
        for (i = 0; i < 6; i++) send_item(next_read_word((i == 1 || i == 2) ? 100 : 0));
    endtask

    task automatic test_passes_limit();
        int i;
        write_register(CFG_WORD_COUNT, 17'd2);
        write_register(CFG_PASSES, 17'd255);
        for (i = 0; i < 6; i++) send_item(next_read_word(i == 3 ? 100 : 0));
    endtask

    // Hold the result side off while items keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (40) send_item(next_read_word(5));
    endtask

    // One word, one pass: run the pattern index through its top and back to zero
    task automatic test_pattern_wrap();
        write_register(CFG_WORD_COUNT, 17'd1);
        write_register(CFG_PASSES, 17'd1);
        repeat (400) send_item(next_read_word(8));
    endtask

    task automatic run_random_chunk(input int items);
        int          roll;
        int          count;
        logic [16:0] words;
        logic [16:0] passes;
        roll = $urandom_range(99);
        if (roll < 60) words = 17'($urandom_range(8, 1));
        else if (roll < 80) words = 17'($urandom_range(40, 9));
        else if (roll < 88) words = 17'd0;
        else if (roll < 94) words = 17'($urandom_range(65535, 41));
        else words = 17'($urandom_range(131071, 65536));
        // large memories only get a few items so the march stays short
        count = (words > 17'd40 || words == 17'd0 && roll >= 88) ? 10 : items;
        roll = $urandom_range(99);
        if (roll < 70) passes = 17'($urandom_range(3, 1));
        else if (roll < 80) passes = {9'($urandom_range(511)), 8'd0};
        else if (roll < 90) passes = 17'd255;
        else passes = 17'($urandom_range(131071));
        if ($urandom_range(1)) begin
            write_register(CFG_WORD_COUNT, words);
            write_register(CFG_PASSES, passes);
        end else begin
            write_register(CFG_PASSES, passes);
            write_register(CFG_WORD_COUNT, words);
        end
        if ($urandom_range(9) == 0) write_register(CFG_SPARE_LO, 17'($urandom_range(131071)));
        repeat (count) send_item(next_read_word(10));
    endtask

    // Random configurations under each idling mix
    task automatic test_random_march();
        int mode;
        int sender_pct [4];
        int receiver_pct [4];
        sender_pct = '{0, 51, 0, 27};
        receiver_pct = '{0, 0, 51, 27};
        for (mode = 0; mode < 4; mode++) begin
            send_idle_pct = sender_pct[mode];
            recv_stall_pct = receiver_pct[mode];
            repeat (10) run_random_chunk(30);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_and_clamp();
        test_zero_registers();
        test_passes_limit();
        test_backpressure();
        test_pattern_wrap();
        test_random_march();

        // Drain and let any stray result show up
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (check_failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
